/* rtl/midpoint_ellipse_stepper_assert.svh */
// ----------------------------------------------------------------------------
// Midpoint ellipse stepper assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_STEPPER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_STEPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MES_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("midpoint_ellipse_stepper: assertion failed");

// next-cycle implication
`define MES_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("midpoint_ellipse_stepper: assertion failed");

`else

`define MES_ASSERT(lbl, clk, rst, ante, cons)
`define MES_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/mes_pkg.sv */
// ----------------------------------------------------------------------------
// mes_pkg
// Shared widths, register indexes, command codes and types of the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package mes_pkg;

  localparam int COORD_WIDTH_DEF = 10;

  localparam int CFG_W = 10;
  localparam int RAD_W = 9;
  localparam int PT_W  = 12;
  localparam int X_W   = 10;
  localparam int Y_W   = 11;
  localparam int D_W   = 42;
  localparam int SQ_W  = 2 * RAD_W;
  localparam int T_W   = 22;
  localparam int MA_W  = 23;
  localparam int MB_W  = SQ_W + 1;
  localparam int IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS_X = 2'd2,
    CFG_RADIUS_Y = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SQ_X,
    MUL_SQ_Y,
    MUL_PROD_X,
    MUL_PROD_Y,
    MUL_TX_SQ,
    MUL_T_RY2,
    MUL_TY_SQ,
    MUL_T_RX2,
    MUL_RX2_RY2,
    MUL_RX2_RY
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_START,
    ACC_LOAD,
    ACC_ADD4,
    ACC_SUB4,
    ACC_UPD1,
    ACC_UPD2
  } acc_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_INIT_MUL,
    ST_INIT_SET,
    ST_PROD_X,
    ST_PROD_Y,
    ST_DECIDE,
    ST_ENT1,
    ST_ENT2,
    ST_ENT3,
    ST_ENT4,
    ST_ENT5,
    ST_ENT6,
    ST_EMIT,
    ST_EMIT_ZERO,
    ST_UPD1,
    ST_UPD2
  } state_t;

  typedef struct packed {
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    emit;
    logic    emit_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic region2;
    logic lt;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/mes_regs.sv */
// ----------------------------------------------------------------------------
// mes_regs
// Configuration register file: ellipse center and radii.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_regs
  import mes_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic      [CFG_W-1:0] center_x,
  output logic      [CFG_W-1:0] center_y,
  output logic      [RAD_W-1:0] radius_x,
  output logic      [RAD_W-1:0] radius_y
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius_x <= RAD_W'(1);
      radius_y <= RAD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_RADIUS_X: radius_x <= cfg_data[RAD_W-1:0];
        CFG_RADIUS_Y: radius_y <= cfg_data[RAD_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mes_ctrl.sv */
// ----------------------------------------------------------------------------
// mes_ctrl
// Sequencer: walks each item through the shared multiplier and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_ctrl
  import mes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_valid,
  output logic          step_ready,
  input  wire logic     start_req,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state, state_next;
  logic   is_start, is_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      is_start <= 1'b0;
    end else begin
      state    <= state_next;
      is_start <= is_start_next;
    end
  end

  always_comb begin
    state_next    = state;
    is_start_next = is_start;
    step_ready    = 1'b0;
    cmd           = '{mul_op: MUL_NONE, acc_op: ACC_NONE, emit: 1'b0, emit_zero: 1'b0};
    unique case (state)
      ST_IDLE: begin
        step_ready = 1'b1;
        if (step_valid) begin
          is_start_next = start_req;
          if (start_req || stat.active) begin
            state_next = ST_SQ_X;
          end else begin
            state_next = ST_EMIT_ZERO;
          end
        end
      end
      ST_SQ_X: begin
        cmd.mul_op = MUL_SQ_X;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.mul_op = MUL_SQ_Y;
        state_next = is_start ? ST_INIT_MUL : ST_PROD_X;
      end
      ST_INIT_MUL: begin
        cmd.mul_op = MUL_RX2_RY;
        state_next = ST_INIT_SET;
      end
      ST_INIT_SET: begin
        cmd.acc_op = ACC_START;
        state_next = ST_EMIT_ZERO;
      end
      ST_PROD_X: begin
        cmd.mul_op = MUL_PROD_X;
        state_next = ST_PROD_Y;
      end
      ST_PROD_Y: begin
        cmd.mul_op = MUL_PROD_Y;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.region2 && !stat.lt) begin
          state_next = ST_ENT1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_ENT1: begin
        cmd.mul_op = MUL_TX_SQ;
        state_next = ST_ENT2;
      end
      ST_ENT2: begin
        cmd.mul_op = MUL_T_RY2;
        state_next = ST_ENT3;
      end
      ST_ENT3: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_op = MUL_TY_SQ;
        state_next = ST_ENT4;
      end
      ST_ENT4: begin
        cmd.mul_op = MUL_T_RX2;
        state_next = ST_ENT5;
      end
      ST_ENT5: begin
        cmd.acc_op = ACC_ADD4;
        cmd.mul_op = MUL_RX2_RY2;
        state_next = ST_ENT6;
      end
      ST_ENT6: begin
        cmd.acc_op = ACC_SUB4;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_UPD1;
        end
      end
      ST_EMIT_ZERO: begin
        if (!stat.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_UPD1: begin
        cmd.acc_op = ACC_UPD1;
        state_next = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.acc_op = ACC_UPD2;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mes_dp.sv */
// ----------------------------------------------------------------------------
// mes_dp
// Datapath: walk state, shared multiplier, decision accumulator, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_dp
  import mes_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  input  wire logic       [CFG_W-1:0] center_x,
  input  wire logic       [CFG_W-1:0] center_y,
  input  wire logic       [RAD_W-1:0] radius_x,
  input  wire logic       [RAD_W-1:0] radius_y,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output logic signed     [PT_W-1:0]  pt0_x,
  output logic signed     [PT_W-1:0]  pt0_y,
  output logic signed     [PT_W-1:0]  pt1_x,
  output logic signed     [PT_W-1:0]  pt1_y,
  output logic signed     [PT_W-1:0]  pt2_x,
  output logic signed     [PT_W-1:0]  pt2_y,
  output logic signed     [PT_W-1:0]  pt3_x,
  output logic signed     [PT_W-1:0]  pt3_y,
  output logic                        points_valid,
  output logic                        final_res
);

  localparam logic [PT_W-1:0] CMASK = PT_W'((1 << COORD_WIDTH) - 1);

  logic        [SQ_W-1:0] rx2, ry2;
  logic        [T_W-1:0]  t;
  logic signed [D_W-1:0]  p1, p2, prod, d;
  logic        [X_W-1:0]  x;
  logic signed [Y_W-1:0]  y;
  logic                   region2, active, turn, fin;

  logic        [X_W:0]    tx;
  logic signed [Y_W:0]    ty;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [D_W-1:0]  mul_p;
  logic signed [D_W-1:0]  rx2_e, ry2_e;
  logic        [PT_W-1:0] cx, cy, xe, ye;
  logic                   fin_now;

  assign tx    = {x, 1'b1};
  assign ty    = (Y_W+1)'(y) - (Y_W+1)'(1);
  assign rx2_e = D_W'(rx2);
  assign ry2_e = D_W'(ry2);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_SQ_X: begin
        mul_a = MA_W'(radius_x);
        mul_b = MB_W'(radius_x);
      end
      MUL_SQ_Y: begin
        mul_a = MA_W'(radius_y);
        mul_b = MB_W'(radius_y);
      end
      MUL_PROD_X: begin
        mul_a = MA_W'(x);
        mul_b = MB_W'(ry2);
      end
      MUL_PROD_Y: begin
        mul_a = MA_W'(y);
        mul_b = MB_W'(rx2);
      end
      MUL_TX_SQ: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      MUL_T_RY2: begin
        mul_a = MA_W'(t);
        mul_b = MB_W'(ry2);
      end
      MUL_TY_SQ: begin
        mul_a = MA_W'(ty);
        mul_b = MB_W'(ty);
      end
      MUL_T_RX2: begin
        mul_a = MA_W'(t);
        mul_b = MB_W'(rx2);
      end
      MUL_RX2_RY2: begin
        mul_a = MA_W'(rx2);
        mul_b = MB_W'(ry2);
      end
      MUL_RX2_RY: begin
        mul_a = MA_W'(rx2);
        mul_b = MB_W'(radius_y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    unique case (cmd.mul_op)
      MUL_SQ_X:                          rx2  <= mul_p[SQ_W-1:0];
      MUL_SQ_Y:                          ry2  <= mul_p[SQ_W-1:0];
      MUL_PROD_X:                        p1   <= mul_p;
      MUL_PROD_Y:                        p2   <= mul_p;
      MUL_TX_SQ, MUL_TY_SQ:              t    <= mul_p[T_W-1:0];
      MUL_T_RY2, MUL_T_RX2,
      MUL_RX2_RY2, MUL_RX2_RY:           prod <= mul_p;
      default: ;
    endcase
  end

  assign fin_now = region2 && (y[Y_W-1] || (y == '0));

  // decision value and walk position
  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      ACC_START: begin
        d <= (ry2_e <<< 2) + rx2_e - (prod <<< 2);
        x <= '0;
        y <= Y_W'(radius_y);
      end
      ACC_LOAD: d <= prod;
      ACC_ADD4: d <= d + (prod <<< 2);
      ACC_SUB4: d <= d - (prod <<< 2);
      ACC_UPD1: begin
        if (!region2) begin
          turn <= !d[D_W-1];
          d    <= d + (p1 <<< 3) + (ry2_e <<< 3) + (ry2_e <<< 2);
          x    <= x + X_W'(1);
        end else begin
          turn <= d[D_W-1] || (d == '0);
          d    <= d - (p2 <<< 3) + (rx2_e <<< 3) + (rx2_e <<< 2);
          y    <= y - Y_W'(1);
        end
      end
      ACC_UPD2: begin
        if (turn) begin
          if (!region2) begin
            d <= d - (p2 <<< 3) + (rx2_e <<< 3);
            y <= y - Y_W'(1);
          end else begin
            d <= d + (p1 <<< 3) + (ry2_e <<< 3);
            x <= x + X_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region2 <= 1'b0;
      active  <= 1'b0;
    end else begin
      if (cmd.acc_op == ACC_START) begin
        region2 <= 1'b0;
        active  <= 1'b1;
      end else if (cmd.acc_op == ACC_SUB4) begin
        region2 <= 1'b1;
      end else if (cmd.acc_op == ACC_UPD2 && fin) begin
        active  <= 1'b0;
      end
    end
  end

  assign cx = {{(PT_W-CFG_W){1'b0}}, center_x} & CMASK;
  assign cy = {{(PT_W-CFG_W){1'b0}}, center_y} & CMASK;
  assign xe = PT_W'(x);
  assign ye = PT_W'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_zero) begin
        pt0_x        <= '0;
        pt0_y        <= '0;
        pt1_x        <= '0;
        pt1_y        <= '0;
        pt2_x        <= '0;
        pt2_y        <= '0;
        pt3_x        <= '0;
        pt3_y        <= '0;
        points_valid <= 1'b0;
        final_res    <= 1'b0;
      end else begin
        pt0_x        <= cx + xe;
        pt0_y        <= cy - ye;
        pt1_x        <= cx - xe;
        pt1_y        <= cy + ye;
        pt2_x        <= cx + xe;
        pt2_y        <= cy + ye;
        pt3_x        <= cx - xe;
        pt3_y        <= cy - ye;
        points_valid <= 1'b1;
        final_res    <= fin_now;
        fin          <= fin_now;
      end
    end
  end

  assign stat.active   = active;
  assign stat.region2  = region2;
  assign stat.lt       = p1 < p2;
  assign stat.out_busy = res_valid && !res_ready;

endmodule

`default_nettype wire

/* rtl/midpoint_ellipse_stepper.sv */
// ----------------------------------------------------------------------------
// midpoint_ellipse_stepper
// Midpoint ellipse rasterizer: one quadrant walk, four mirrored points a step.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  --------------------------------------------
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//  step     step_valid/step_ready  start_req
//  res      res_valid/res_ready    pt0..pt3 x/y, points_valid, final_res
//
//  A start item squares the radii and emits zeros; a step item emits points
//  and updates the walk, or emits zeros with no walk in progress. All products
//  go through one shared 23x19 multiplier, one per cycle.
//  Reset: synchronous, clears the walk; radii reset to 1, centers to 0.
//  A waiting result holds in the output register; the next item is taken
//  while it waits and stalls only when its own result is ready to load.
//
`default_nettype none

`include "midpoint_ellipse_stepper_assert.svh"

module midpoint_ellipse_stepper
  import mes_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic       [IDX_W-1:0] cfg_index,
  input  wire logic       [CFG_W-1:0] cfg_data,
  input  wire logic                   step_valid,
  output logic                        step_ready,
  input  wire logic                   start_req,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output logic signed     [PT_W-1:0]  pt0_x,
  output logic signed     [PT_W-1:0]  pt0_y,
  output logic signed     [PT_W-1:0]  pt1_x,
  output logic signed     [PT_W-1:0]  pt1_y,
  output logic signed     [PT_W-1:0]  pt2_x,
  output logic signed     [PT_W-1:0]  pt2_y,
  output logic signed     [PT_W-1:0]  pt3_x,
  output logic signed     [PT_W-1:0]  pt3_y,
  output logic                        points_valid,
  output logic                        final_res
);

  logic [CFG_W-1:0] center_x, center_y;
  logic [RAD_W-1:0] radius_x, radius_y;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  mes_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y)
  );

  mes_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .start_req  (start_req),
    .cmd        (cmd),
    .stat       (stat)
  );

  mes_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .pt0_x        (pt0_x),
    .pt0_y        (pt0_y),
    .pt1_x        (pt1_x),
    .pt1_y        (pt1_y),
    .pt2_x        (pt2_x),
    .pt2_y        (pt2_y),
    .pt3_x        (pt3_x),
    .pt3_y        (pt3_y),
    .points_valid (points_valid),
    .final_res    (final_res)
  );

  `MES_ASSERT_NEXT(a_accept_blocks, clk, rst, step_valid && step_ready, !step_ready)
  `MES_ASSERT(a_final_plots, clk, rst, res_valid && final_res, points_valid)
  `MES_ASSERT(a_idle_zero, clk, rst, res_valid && !points_valid, pt0_x == '0 && pt3_y == '0 && !final_res)

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse stepper testbench
// Drives start and step items with random gaps and receiver stalls, predicts
// the mirrored quadrant points of every step and checks each result in order.
// Radii and centers change between phases, extremes and zero radii included.
// ----------------------------------------------------------------------------
module tb;
  import mes_pkg::*;

  localparam int     ITEM_TARGET = 1850;
  localparam int     QUIET_LIMIT = 3000;
  localparam longint COORD_MASK  = (longint'(1) << COORD_WIDTH_DEF) - 1;

  typedef struct packed {
    logic signed [PT_W-1:0] pt0_x;
    logic signed [PT_W-1:0] pt0_y;
    logic signed [PT_W-1:0] pt1_x;
    logic signed [PT_W-1:0] pt1_y;
    logic signed [PT_W-1:0] pt2_x;
    logic signed [PT_W-1:0] pt2_y;
    logic signed [PT_W-1:0] pt3_x;
    logic signed [PT_W-1:0] pt3_y;
    logic                   plot;
    logic                   last;
  } quad_points_t;

  typedef struct packed {
    logic        [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic signed [D_W-1:0] dec;
    logic                  region2;
    logic                  active;
    quad_points_t          pts;
  } walk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              step_valid = 1'b0;
  logic              step_ready;
  logic              start_req = 1'b0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic signed [PT_W-1:0] pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y;
  logic              points_valid;
  logic              final_res;

  logic [CFG_W-1:0] ctr_x = '0;
  logic [CFG_W-1:0] ctr_y = '0;
  logic [RAD_W-1:0] rad_x = RAD_W'(1);
  logic [RAD_W-1:0] rad_y = RAD_W'(1);

  walk_t        walk_now  = '0;
  walk_t        walk_plan = '0;
  quad_points_t want;
  quad_points_t expected_points[$];
  logic         step_queue[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stim_count    = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit hold_armed    = 1'b0;
  bit hold_spent    = 1'b0;

  midpoint_ellipse_stepper i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .start_req    (start_req),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .pt0_x        (pt0_x),
    .pt0_y        (pt0_y),
    .pt1_x        (pt1_x),
    .pt1_y        (pt1_y),
    .pt2_x        (pt2_x),
    .pt2_y        (pt2_y),
    .pt3_x        (pt3_x),
    .pt3_y        (pt3_y),
    .points_valid (points_valid),
    .final_res    (final_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic walk_t next_walk(walk_t w, logic go);
    longint rx, ry, rx2, ry2, xi, yi, d, tx, ty, cxl, cyl;
    logic   fin, move;
    walk_t  n;
    n     = w;
    n.pts = '0;
    rx    = rad_x;
    ry    = rad_y;
    rx2   = rx * rx;
    ry2   = ry * ry;
    cxl   = longint'(ctr_x) & COORD_MASK;
    cyl   = longint'(ctr_y) & COORD_MASK;
    if (go) begin
      n.x       = '0;
      n.y       = Y_W'(ry);
      n.dec     = D_W'(4 * ry2 - 4 * rx2 * ry + rx2);
      n.region2 = 1'b0;
      n.active  = 1'b1;
      return n;
    end
    if (!w.active) return n;
    xi = longint'(w.x);
    yi = longint'($signed(w.y));
    d  = longint'($signed(w.dec));
    if (!n.region2 && !(xi * ry2 < yi * rx2)) begin
      tx        = 2 * xi + 1;
      ty        = yi - 1;
      d         = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
      n.region2 = 1'b1;
    end
    n.pts.pt0_x = PT_W'(cxl + xi);
    n.pts.pt0_y = PT_W'(cyl - yi);
    n.pts.pt1_x = PT_W'(cxl - xi);
    n.pts.pt1_y = PT_W'(cyl + yi);
    n.pts.pt2_x = PT_W'(cxl + xi);
    n.pts.pt2_y = PT_W'(cyl + yi);
    n.pts.pt3_x = PT_W'(cxl - xi);
    n.pts.pt3_y = PT_W'(cyl - yi);
    n.pts.plot  = 1'b1;
    fin         = n.region2 && (yi <= 0);
    n.pts.last  = fin;
    if (!n.region2) begin
      move = (d >= 0);
      xi   = xi + 1;
      d    = d + 8 * ry2 * xi + 4 * ry2;
      if (move) begin
        yi = yi - 1;
        d  = d - 8 * rx2 * yi;
      end
    end else begin
      move = (d <= 0);
      yi   = yi - 1;
      d    = d + 4 * rx2 - 8 * rx2 * yi;
      if (move) begin
        xi = xi + 1;
        d  = d + 8 * ry2 * xi;
      end
    end
    if (fin) n.active = 1'b0;
    n.x   = X_W'(xi);
    n.y   = Y_W'(yi);
    n.dec = D_W'(d);
    return n;
  endfunction

  function automatic void queue_item(logic go);
    if (go || walk_plan.active) stim_count++;
    walk_plan = next_walk(walk_plan, go);
    step_queue.push_back(go);
  endfunction

  function automatic void queue_walk(logic restart, int cap, int extra);
    int n;
    n = 0;
    if (restart) queue_item(1'b1);
    while (walk_plan.active && n < cap) begin
      queue_item(1'b0);
      n++;
    end
    repeat (extra) queue_item(1'b0);
  endfunction

  function automatic logic [CFG_W-1:0] pick_radius();
    int               sel;
    logic [CFG_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 4) v = '0;
    else if (sel < 75) v = CFG_W'($urandom_range(1, 12));
    else if (sel < 93) v = CFG_W'($urandom_range(13, 60));
    else v = CFG_W'($urandom_range(400, 511));
    v[CFG_W-1] = $urandom_range(1);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_center();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return CFG_W'($urandom);
  endfunction

  function automatic void check_field(string name, logic [PT_W-1:0] exp_v,
                                      logic [PT_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      error_count++;
    end
  endfunction

  task automatic set_traffic(int mode);
    case (mode)
      0: begin
        send_idle_pct = 24;
        recv_idle_pct = 54;
      end
      1: begin
        send_idle_pct = 54;
        recv_idle_pct = 24;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X: ctr_x = data;
      CFG_CENTER_Y: ctr_y = data;
      CFG_RADIUS_X: rad_x = data[RAD_W-1:0];
      CFG_RADIUS_Y: rad_y = data[RAD_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (step_queue.size() != 0 || step_valid || expected_points.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  // step driver: predict on accept, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else begin
      if (step_valid && step_ready) begin
        walk_now = next_walk(walk_now, start_req);
        expected_points.push_back(walk_now.pts);
      end
      if (!step_valid || step_ready) begin
        if (step_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          step_valid <= 1'b1;
          start_req  <= step_queue.pop_front();
        end else begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_points.size() == 0) begin
          $error("result item with no step pending");
          error_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("pt0_x", want.pt0_x, pt0_x);
          check_field("pt0_y", want.pt0_y, pt0_y);
          check_field("pt1_x", want.pt1_x, pt1_x);
          check_field("pt1_y", want.pt1_y, pt1_y);
          check_field("pt2_x", want.pt2_x, pt2_x);
          check_field("pt2_y", want.pt2_y, pt2_y);
          check_field("pt3_x", want.pt3_x, pt3_x);
          check_field("pt3_y", want.pt3_y, pt3_y);
          check_field("points_valid", PT_W'(want.plot), PT_W'(points_valid));
          check_field("final_res", PT_W'(want.last), PT_W'(final_res));
        end
      end
      if (hold_armed && !hold_spent) begin
        hold_spent <= 1'b1;
        hold_left  <= 250;
        res_ready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (step_valid && step_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sel, phase, phase_goal, cap, mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_traffic(0);

    // step with no walk, then a unit circle at the origin
    queue_item(1'b0);
    queue_walk(1'b1, 4096, 1);
    drain();

    write_reg(CFG_CENTER_X, '1);
    write_reg(CFG_CENTER_Y, '1);
    write_reg(CFG_RADIUS_X, CFG_W'(10'h205));
    write_reg(CFG_RADIUS_Y, '0);
    queue_walk(1'b1, 4096, 1);
    drain();

    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '1);
    write_reg(CFG_RADIUS_X, '0);
    write_reg(CFG_RADIUS_Y, '0);
    queue_walk(1'b1, 4096, 1);
    drain();

    // restart mid-walk, then change radius and center mid-walk
    write_reg(CFG_CENTER_X, CFG_W'(512));
    write_reg(CFG_CENTER_Y, CFG_W'(512));
    write_reg(CFG_RADIUS_X, CFG_W'(4));
    write_reg(CFG_RADIUS_Y, CFG_W'(6));
    queue_walk(1'b1, 3, 0);
    queue_walk(1'b1, 2, 0);
    drain();
    write_reg(CFG_RADIUS_X, CFG_W'(6));
    write_reg(CFG_CENTER_X, CFG_W'(100));
    queue_walk(1'b0, 4096, 1);
    drain();

    write_reg(CFG_RADIUS_X, CFG_W'(511));
    write_reg(CFG_RADIUS_Y, CFG_W'(511));
    write_reg(CFG_CENTER_Y, '0);
    queue_walk(1'b1, 3, 0);
    drain();

    stim_count = 0;
    phase      = 0;
    while (stim_count < ITEM_TARGET) begin
      mode = stim_count * 3 / ITEM_TARGET;
      set_traffic(mode);
      if (phase == 1) hold_armed = 1'b1;
      write_reg(CFG_CENTER_X, pick_center());
      write_reg(CFG_CENTER_Y, pick_center());
      write_reg(CFG_RADIUS_X, pick_radius());
      write_reg(CFG_RADIUS_Y, pick_radius());
      cap        = (rad_x > 100 || rad_y > 100) ? 40 : 4096;
      phase_goal = stim_count + $urandom_range(60, 140);
      while (stim_count < phase_goal) begin
        sel = $urandom_range(99);
        if (sel < 80) queue_walk(1'b1, $urandom_range(cap / 4, cap), $urandom_range(0, 2));
        else if (sel < 90) queue_walk(1'b1, $urandom_range(0, 6), 0);
        else repeat ($urandom_range(1, 3)) queue_item(1'b0);
      end
      drain();
      phase++;
    end

    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
